// File: src/dns_message_parser_core_assert.svh
// Assertion macros for the DNS message parser core.
`ifndef DNS_MESSAGE_PARSER_CORE_ASSERT_SVH
`define DNS_MESSAGE_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DMP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dns parser assertion failed");
// Next-cycle implication.
`define DMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dns parser assertion failed");
`else
`define DMP_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define DMP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: src/dmp_pkg.sv
// Types, codes and small tables shared by the DNS message parser core.
package dmp_pkg;

    // Parse phase; its encoding is also the reported section code.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_QFIXED = 3'd2,
        PH_ANAME  = 3'd3,
        PH_AFIXED = 3'd4,
        PH_RDATA  = 3'd5,
        PH_IGNORE = 3'd6
    } phase_t;

    localparam logic [3:0] FID_FLAGS   = 4'd1;
    localparam logic [3:0] FID_QDCOUNT = 4'd2;
    localparam logic [3:0] FID_ANCOUNT = 4'd3;
    localparam logic [3:0] FID_QTYPE   = 4'd6;
    localparam logic [3:0] FID_ATYPE   = 4'd8;
    localparam logic [3:0] FID_ACLASS  = 4'd9;
    localparam logic [3:0] FID_TTL     = 4'd10;
    localparam logic [3:0] FID_RDLEN   = 4'd11;
    localparam logic [3:0] FID_RDATA   = 4'd12;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd1;
    localparam logic [1:0] ERR_LABEL_TYPE = 2'd2;
    localparam logic [1:0] ERR_NAME_LONG  = 2'd3;

    localparam logic [15:0] FLAG_KEEP_MASK = 16'hFF8F;
    localparam logic [1:0]  LABEL_PTR      = 2'b11;
    localparam logic [7:0]  NAME_MAX       = 8'd255;

    localparam logic [3:0] HDR_LAST_BYTE  = 4'd11;
    localparam logic [3:0] QFIX_LAST_BYTE = 4'd3;
    localparam logic [3:0] AFIX_LAST_BYTE = 4'd9;
    localparam logic [3:0] PTR_LOW_BYTE   = 4'd1;

    // Field carried by each byte of the fixed part of an answer.
    function automatic logic [3:0] afix_field(input logic [3:0] idx);
        logic [3:0] f;
        case (idx)
            4'd0, 4'd1:               f = FID_ATYPE;
            4'd2, 4'd3:               f = FID_ACLASS;
            4'd4, 4'd5, 4'd6, 4'd7:   f = FID_TTL;
            default:                  f = FID_RDLEN;
        endcase
        return f;
    endfunction

    // High on the byte that completes a field of the answer's fixed part.
    function automatic logic afix_done(input logic [3:0] idx);
        logic d;
        case (idx)
            4'd1, 4'd3, 4'd7, 4'd9: d = 1'b1;
            default:                d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// File: src/dns_message_parser_core.sv
// Byte-serial DNS message parser: header, questions and the first answer.
//
// Usage: the message enters on the s_ channel one byte per transfer, in wire
// order, with s_tlast on its final byte. Every input byte yields exactly one
// result transfer on the m_ channel, in the same order. m_tuser is the section
// the byte belongs to; m_tdata tells which header or fixed field it completes
// (with its value), the name byte it carries, a completed compression pointer
// and any parse error. m_tlast copies s_tlast.
// A byte is captured in the input register at its transfer, and its result is
// loaded into the result register once that register is empty or being taken.
// Throughput: one byte per cycle unless the receiver stalls; the phase machine
// and its counters update between the two registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of a header. After a byte with s_tlast the parser also
// returns to that state, ready for the next message.
// When the receiver stalls, the result register holds; one more byte can wait
// in the input register, after which s_tready goes low until m_tready returns.
`include "dns_message_parser_core_assert.svh"

module dns_message_parser_core
    import dmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // field_id, field_value, field_done, name_byte,
                                   // name_byte_valid, pointer_offset, pointer_seen,
                                   // parse_error, zero pad
    output logic [2:0]  m_tuser,   // section
    output logic        m_tlast    // packet_done
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  bif_reg, bif_next;
    logic [31:0] accum_reg, accum_next;
    logic [15:0] qleft_reg, qleft_next;
    logic        ans_reg, ans_next;
    logic [5:0]  label_reg, label_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic [15:0] rdleft_reg, rdleft_next;
    logic [5:0]  phigh_reg, phigh_next;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  sec_reg;
    logic [3:0]  fid_reg;
    logic [31:0] fval_reg;
    logic        fdone_reg;
    logic [7:0]  nb_reg;
    logic        nbv_reg;
    logic [13:0] poff_reg;
    logic        pseen_reg;
    logic [1:0]  err_reg;
    logic        pdone_reg;

    // Result of the byte in the input register.
    logic [2:0]  o_sec;
    logic [3:0]  o_fid;
    logic [31:0] o_fval;
    logic        o_fdone;
    logic [7:0]  o_nb;
    logic        o_nbv;
    logic [13:0] o_poff;
    logic        o_pseen;
    logic [1:0]  o_err;

    logic        advance;
    logic        fire;
    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [15:0] v16;
    logic [15:0] q_after;
    logic [15:0] rd_after;
    logic [3:0]  afix_idx;
    logic        ended;
    logic        emit;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Phase machine: next state and the result of the current byte.
    always_comb begin
        phase_next  = phase_reg;
        bif_next    = bif_reg;
        accum_next  = accum_reg;
        qleft_next  = qleft_reg;
        ans_next    = ans_reg;
        label_next  = label_reg;
        nlen_next   = nlen_reg;
        rdleft_next = rdleft_reg;
        phigh_next  = phigh_reg;

        b         = in_byte_reg;
        acc_shift = {accum_reg[23:0], b};
        v16       = acc_shift[15:0];
        q_after   = qleft_reg;
        rd_after  = rdleft_reg - 16'd1;
        afix_idx  = (bif_reg > AFIX_LAST_BYTE) ? AFIX_LAST_BYTE : bif_reg;
        ended     = 1'b0;
        emit      = 1'b0;

        o_sec   = phase_reg;
        o_fid   = '0;
        o_fval  = '0;
        o_fdone = 1'b0;
        o_nb    = '0;
        o_nbv   = 1'b0;
        o_poff  = '0;
        o_pseen = 1'b0;
        o_err   = ERR_NONE;

        unique case (phase_reg)
            PH_HEADER: begin
                accum_next = acc_shift;
                o_fid      = {1'b0, bif_reg[3:1]};
                if (bif_reg[0]) begin
                    if (o_fid == FID_FLAGS) begin
                        v16 = acc_shift[15:0] & FLAG_KEEP_MASK;
                    end
                    o_fdone    = 1'b1;
                    o_fval     = {16'd0, v16};
                    accum_next = '0;
                    if (o_fid == FID_QDCOUNT) begin
                        qleft_next = v16;
                    end
                    if (o_fid == FID_ANCOUNT) begin
                        ans_next = (v16 != 16'd0);
                    end
                end
                bif_next = bif_reg + 4'd1;
                if (bif_reg == HDR_LAST_BYTE) begin
                    bif_next = '0;
                    if (qleft_reg != 16'd0) begin
                        phase_next = PH_QNAME;
                    end else if (ans_reg) begin
                        phase_next = PH_ANAME;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                    label_next = '0;
                    nlen_next  = '0;
                    phigh_next = '0;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (bif_reg == PTR_LOW_BYTE) begin
                    o_poff  = {phigh_reg, b};
                    o_pseen = 1'b1;
                    ended   = 1'b1;
                end else if (label_reg != 6'd0 || b == 8'd0) begin
                    emit = 1'b1;
                end else if (b[7:6] == LABEL_PTR) begin
                    phigh_next = b[5:0];
                    bif_next   = PTR_LOW_BYTE;
                end else if (b[7:6] != 2'b00) begin
                    o_err      = ERR_LABEL_TYPE;
                    phase_next = PH_IGNORE;
                end else begin
                    emit = 1'b1;
                end
                if (emit) begin
                    if (nlen_reg == NAME_MAX) begin
                        o_err      = ERR_NAME_LONG;
                        phase_next = PH_IGNORE;
                    end else begin
                        nlen_next = nlen_reg + 8'd1;
                        o_nb      = b;
                        o_nbv     = 1'b1;
                        if (label_reg != 6'd0) begin
                            label_next = label_reg - 6'd1;
                        end else if (b == 8'd0) begin
                            ended = 1'b1;
                        end else begin
                            // Top bits are zero here, so the length fits.
                            label_next = b[5:0];
                        end
                    end
                end
                if (ended) begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    bif_next   = '0;
                    accum_next = '0;
                end
            end
            PH_QFIXED: begin
                accum_next = acc_shift;
                o_fid      = FID_QTYPE + {3'd0, bif_reg[1]};
                if (bif_reg[0]) begin
                    o_fdone    = 1'b1;
                    o_fval     = {16'd0, acc_shift[15:0]};
                    accum_next = '0;
                end
                bif_next = bif_reg + 4'd1;
                if (bif_reg == QFIX_LAST_BYTE) begin
                    bif_next   = '0;
                    q_after    = qleft_reg - 16'd1;
                    qleft_next = q_after;
                    if (q_after != 16'd0) begin
                        phase_next = PH_QNAME;
                    end else if (ans_reg) begin
                        phase_next = PH_ANAME;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                    label_next = '0;
                    nlen_next  = '0;
                    phigh_next = '0;
                end
            end
            PH_AFIXED: begin
                accum_next = acc_shift;
                o_fid      = afix_field(afix_idx);
                if (afix_done(afix_idx)) begin
                    o_fdone    = 1'b1;
                    o_fval     = acc_shift;
                    accum_next = '0;
                end
                bif_next = bif_reg + 4'd1;
                if (afix_idx == AFIX_LAST_BYTE) begin
                    bif_next    = '0;
                    rdleft_next = acc_shift[15:0];
                    phase_next  = (acc_shift[15:0] != 16'd0) ? PH_RDATA : PH_IGNORE;
                end
            end
            PH_RDATA: begin
                o_fid       = FID_RDATA;
                o_fval      = {24'd0, b};
                rdleft_next = rd_after;
                if (rd_after == 16'd0) begin
                    o_fdone    = 1'b1;
                    phase_next = PH_IGNORE;
                end
            end
            default: begin
            end
        endcase

        if (in_last_reg) begin
            if (o_err == ERR_NONE && phase_next != PH_IGNORE) begin
                o_err = ERR_TRUNCATED;
            end
            phase_next  = PH_HEADER;
            bif_next    = '0;
            accum_next  = '0;
            qleft_next  = '0;
            ans_next    = 1'b0;
            label_next  = '0;
            nlen_next   = '0;
            rdleft_next = '0;
            phigh_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            bif_reg    <= '0;
            accum_reg  <= '0;
            qleft_reg  <= '0;
            ans_reg    <= 1'b0;
            label_reg  <= '0;
            nlen_reg   <= '0;
            rdleft_reg <= '0;
            phigh_reg  <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            bif_reg    <= bif_next;
            accum_reg  <= accum_next;
            qleft_reg  <= qleft_next;
            ans_reg    <= ans_next;
            label_reg  <= label_next;
            nlen_reg   <= nlen_next;
            rdleft_reg <= rdleft_next;
            phigh_reg  <= phigh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            sec_reg   <= o_sec;
            fid_reg   <= o_fid;
            fval_reg  <= o_fval;
            fdone_reg <= o_fdone;
            nb_reg    <= o_nb;
            nbv_reg   <= o_nbv;
            poff_reg  <= o_poff;
            pseen_reg <= o_pseen;
            err_reg   <= o_err;
            pdone_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = sec_reg;
    assign m_tlast  = pdone_reg;
    assign m_tdata  = {1'b0, err_reg, pseen_reg, poff_reg, nbv_reg, nb_reg,
                       fdone_reg, fval_reg, fid_reg};

    // A byte is either a name byte or part of a pointer, never both.
    `DMP_ASSERT_IMPLY(a_ptr_not_name, aclk, aresetn, out_valid_reg, !(pseen_reg && nbv_reg))
    // Label-type and long-name errors only arise inside a name.
    `DMP_ASSERT_IMPLY(a_name_err_sec, aclk, aresetn,
        out_valid_reg && (err_reg == ERR_LABEL_TYPE || err_reg == ERR_NAME_LONG),
        sec_reg == PH_QNAME || sec_reg == PH_ANAME)
    // Header fields completed in the header section are the six header fields.
    `DMP_ASSERT_IMPLY(a_hdr_fid, aclk, aresetn,
        out_valid_reg && fdone_reg && sec_reg == PH_HEADER, fid_reg <= 4'd5)
    // A byte waiting in the input register is not dropped while the output stalls.
    `DMP_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

// File: bench/tb_dns_message_parser_core.sv
// Self-checking testbench for the byte-serial DNS message parser core.
module tb_dns_message_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dmp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 150;
    localparam int MAX_PRINTED = 40;

    // Result word layout of m_tdata, lowest field last.
    typedef struct packed {
        logic        pad;
        logic [1:0]  parse_error;
        logic        pointer_seen;
        logic [13:0] pointer_offset;
        logic        name_valid;
        logic [7:0]  name_byte;
        logic        field_done;
        logic [31:0] field_value;
        logic [3:0]  field_id;
    } parse_result_t;

    typedef struct packed {
        phase_t        section;
        logic          eom;
        parse_result_t fields;
    } parse_expect_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    dns_message_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Parser state mirrored by the predictor.
    phase_t      st_phase;
    logic [3:0]  st_byte_idx;
    logic [31:0] st_accum;
    logic [15:0] st_q_left;
    logic        st_answer;
    logic [5:0]  st_label_left;
    logic [7:0]  st_name_len;
    logic [15:0] st_rdata_left;
    logic [5:0]  st_ptr_high;

    wire_byte_t    send_q[$];
    logic [7:0]    msg_q[$];
    parse_expect_t pending_results[$];

    int   sender_idle_pct   = 38;
    int   receiver_idle_pct = 52;
    logic s_fire            = 1'b0;
    int   quiet_cycles      = 0;
    int   error_count       = 0;
    int   results_seen      = 0;
    int   messages_done     = 0;
    int   name_bytes_seen   = 0;
    int   pointers_seen     = 0;
    int   rdata_ends_seen   = 0;
    int   err_seen[4]       = '{0, 0, 0, 0};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_parser();
        st_phase      = PH_HEADER;
        st_byte_idx   = '0;
        st_accum      = '0;
        st_q_left     = '0;
        st_answer     = 1'b0;
        st_label_left = '0;
        st_name_len   = '0;
        st_rdata_left = '0;
        st_ptr_high   = '0;
    endtask

    task automatic start_name_walk(input phase_t ph);
        st_phase      = ph;
        st_label_left = '0;
        st_name_len   = '0;
        st_byte_idx   = '0;
        st_ptr_high   = '0;
    endtask

    task automatic next_after_questions();
        if (st_q_left != 0) begin
            start_name_walk(PH_QNAME);
        end else if (st_answer) begin
            start_name_walk(PH_ANAME);
        end else begin
            st_phase = PH_IGNORE;
        end
    endtask

    task automatic parse_dns_byte(input logic [7:0] b, input logic eom,
                                  output parse_expect_t r);
        logic [15:0] v;
        logic        ended;
        logic        emit;
        r         = '0;
        r.section = st_phase;
        r.eom     = eom;
        ended     = 1'b0;
        emit      = 1'b0;
        case (st_phase)
            PH_HEADER: begin
                st_accum = {st_accum[23:0], b};
                r.fields.field_id = {1'b0, st_byte_idx[3:1]};
                if (st_byte_idx[0]) begin
                    v = st_accum[15:0];
                    if (r.fields.field_id == FID_FLAGS) v = v & FLAG_KEEP_MASK;
                    r.fields.field_done  = 1'b1;
                    r.fields.field_value = {16'h0000, v};
                    if (r.fields.field_id == FID_QDCOUNT) st_q_left = v;
                    if (r.fields.field_id == FID_ANCOUNT) st_answer = (v != 0);
                    st_accum = '0;
                end
                if (st_byte_idx == HDR_LAST_BYTE) begin
                    st_byte_idx = '0;
                    next_after_questions();
                end else begin
                    st_byte_idx = st_byte_idx + 4'd1;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (st_byte_idx == PTR_LOW_BYTE) begin
                    r.fields.pointer_offset = {st_ptr_high, b};
                    r.fields.pointer_seen   = 1'b1;
                    ended = 1'b1;
                end else if (st_label_left != 0 || b == 8'h00) begin
                    emit = 1'b1;
                end else if (b[7:6] == LABEL_PTR) begin
                    st_ptr_high = b[5:0];
                    st_byte_idx = PTR_LOW_BYTE;
                end else if (b[7:6] != 2'b00) begin
                    r.fields.parse_error = ERR_LABEL_TYPE;
                    st_phase = PH_IGNORE;
                end else begin
                    emit = 1'b1;
                end
                if (emit) begin
                    if (st_name_len == NAME_MAX) begin
                        r.fields.parse_error = ERR_NAME_LONG;
                        st_phase = PH_IGNORE;
                    end else begin
                        st_name_len = st_name_len + 8'd1;
                        r.fields.name_byte  = b;
                        r.fields.name_valid = 1'b1;
                        if (st_label_left != 0) begin
                            st_label_left = st_label_left - 6'd1;
                        end else if (b == 8'h00) begin
                            ended = 1'b1;
                        end else begin
                            st_label_left = b[5:0];
                        end
                    end
                end
                if (ended) begin
                    st_phase    = (st_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    st_byte_idx = '0;
                    st_accum    = '0;
                end
            end
            PH_QFIXED: begin
                st_accum = {st_accum[23:0], b};
                r.fields.field_id = FID_QTYPE + {3'd0, st_byte_idx[1]};
                if (st_byte_idx[0]) begin
                    r.fields.field_done  = 1'b1;
                    r.fields.field_value = {16'h0000, st_accum[15:0]};
                    st_accum = '0;
                end
                if (st_byte_idx == QFIX_LAST_BYTE) begin
                    st_byte_idx = '0;
                    st_q_left   = st_q_left - 16'd1;
                    next_after_questions();
                end else begin
                    st_byte_idx = st_byte_idx + 4'd1;
                end
            end
            PH_AFIXED: begin
                st_accum = {st_accum[23:0], b};
                if (st_byte_idx < 2)      r.fields.field_id = FID_ATYPE;
                else if (st_byte_idx < 4) r.fields.field_id = FID_ACLASS;
                else if (st_byte_idx < 8) r.fields.field_id = FID_TTL;
                else                      r.fields.field_id = FID_RDLEN;
                // Type, class, ttl and rdlength end on bytes 1, 3, 7 and 9.
                if (st_byte_idx[0] && st_byte_idx != 4'd5) begin
                    r.fields.field_done  = 1'b1;
                    r.fields.field_value = st_accum;
                    st_accum = '0;
                end
                if (st_byte_idx >= AFIX_LAST_BYTE) begin
                    st_byte_idx   = '0;
                    st_rdata_left = r.fields.field_value[15:0];
                    st_phase      = (st_rdata_left != 0) ? PH_RDATA : PH_IGNORE;
                end else begin
                    st_byte_idx = st_byte_idx + 4'd1;
                end
            end
            PH_RDATA: begin
                r.fields.field_id    = FID_RDATA;
                r.fields.field_value = {24'h000000, b};
                st_rdata_left = st_rdata_left - 16'd1;
                if (st_rdata_left == 0) begin
                    r.fields.field_done = 1'b1;
                    st_phase = PH_IGNORE;
                end
            end
            default: ;
        endcase
        if (eom) begin
            if (r.fields.parse_error == ERR_NONE && st_phase != PH_IGNORE)
                r.fields.parse_error = ERR_TRUNCATED;
            clear_parser();
        end
    endtask

    // ---------------------------------------------------------------- messages

    task automatic add16(input logic [15:0] v);
        msg_q.push_back(v[15:8]);
        msg_q.push_back(v[7:0]);
    endtask

    task automatic push_rand_bytes(input int n);
        logic [7:0] rb;
        repeat (n) begin
            rb = 8'($urandom);
            msg_q.push_back(rb);
        end
    endtask

    task automatic add_header(input logic [15:0] qd, input logic [15:0] an);
        add16(16'($urandom));
        add16(16'($urandom));
        add16(qd);
        add16(an);
        add16(16'($urandom));
        add16(16'($urandom));
    endtask

    // Mostly short labels, now and then one of up to the full 63 bytes.
    task automatic add_labels(input int n);
        int len;
        repeat (n) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
            msg_q.push_back(len[7:0]);
            push_rand_bytes(len);
        end
    endtask

    task automatic add_name(input bit with_ptr);
        logic [5:0] hi;
        add_labels($urandom_range(0, 3));
        if (with_ptr) begin
            hi = 6'($urandom);
            msg_q.push_back({LABEL_PTR, hi});
            push_rand_bytes(1);
        end else begin
            msg_q.push_back(8'h00);
        end
    endtask

    task automatic build_good();
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] rdlen;
        qd = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) an = 16'h0000;
        else if ($urandom_range(0, 3) == 0) an = 16'($urandom_range(1, 65535));
        else an = 16'h0001;
        add_header(qd, an);
        repeat (qd) begin
            add_name($urandom_range(0, 3) == 0);
            add16(16'($urandom));
            add16(16'($urandom));
        end
        if (an != 0) begin
            add_name($urandom_range(0, 3) == 0);
            repeat (4) add16(16'($urandom));
            rdlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            add16(rdlen);
            push_rand_bytes(int'(rdlen));
        end
        push_rand_bytes($urandom_range(0, 3));
    endtask

    // A length byte with top bits 01 or 10 inside a question or answer name.
    task automatic build_bad_label();
        logic [15:0] qd;
        logic [7:0]  bad;
        qd = 16'($urandom_range(0, 1));
        add_header(qd, (qd == 0) ? 16'h0001 : 16'($urandom_range(0, 1)));
        add_labels($urandom_range(0, 2));
        bad = 8'($urandom_range(8'h40, 8'hBF));
        msg_q.push_back(bad);
        push_rand_bytes($urandom_range(0, 4));
    endtask

    // Four full labels: the name passes 255 bytes inside the fourth.
    task automatic build_long_name();
        add_header(16'($urandom_range(0, 1)), 16'h0001);
        repeat (4) begin
            msg_q.push_back(8'd63);
            push_rand_bytes(63);
        end
        push_rand_bytes($urandom_range(0, 3));
    endtask

    task automatic flush_message(input int keep);
        for (int i = 0; i < keep; i++)
            send_q.push_back('{data: msg_q[i], last: (i == keep - 1)});
        msg_q.delete();
    endtask

    task automatic load_directed();
        // Header with all-ones ID, flags and NS count, the Z bits to clear, then a pointer at the top offset.
        add16(16'hFFFF);
        add16(16'hFFFF);
        add16(16'h0001);
        add16(16'h0000);
        add16(16'hFFFF);
        add16(16'h0000);
        msg_q.push_back(8'hFF);
        msg_q.push_back(8'hFF);
        add16(16'h0000);
        add16(16'hFFFF);
        msg_q.push_back(8'h5A);
        flush_message(msg_q.size());
        // One lone byte: truncated inside the header.
        msg_q.push_back(8'h00);
        flush_message(1);
        // Reserved label type right at the start of the question name.
        add16(16'h0000);
        add16(16'h0000);
        add16(16'h0001);
        add16(16'h0000);
        add16(16'h0000);
        add16(16'hFFFF);
        msg_q.push_back(8'h80);
        flush_message(msg_q.size());
    endtask

    task automatic fill_random(input int target, input bit long_first);
        int added;
        int kind;
        int keep;
        added = 0;
        while (added < target) begin
            kind = $urandom_range(0, 99);
            if (long_first && added == 0) kind = 83;
            if (kind < 74) build_good();
            else if (kind < 82) build_bad_label();
            else if (kind < 85) build_long_name();
            else push_rand_bytes($urandom_range(1, 24));
            keep = msg_q.size();
            // Cut a well-formed message short somewhere in the middle.
            if (kind >= 62 && kind < 74 && keep > 1) keep = $urandom_range(1, keep - 1);
            added += keep;
            flush_message(keep);
        end
    endtask

    task automatic wait_for_drain();
        while (send_q.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    task automatic check_result();
        parse_expect_t want;
        parse_result_t got;
        got = m_tdata;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", m_tdata[31:0], '0);
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser !== want.section)
            report_mismatch("section", 32'(m_tuser), 32'(want.section));
        if (m_tlast !== want.eom)
            report_mismatch("packet_done", 32'(m_tlast), 32'(want.eom));
        if (got.field_id !== want.fields.field_id)
            report_mismatch("field_id", 32'(got.field_id), 32'(want.fields.field_id));
        if (got.field_value !== want.fields.field_value)
            report_mismatch("field_value", got.field_value, want.fields.field_value);
        if (got.field_done !== want.fields.field_done)
            report_mismatch("field_done", 32'(got.field_done), 32'(want.fields.field_done));
        if (got.name_byte !== want.fields.name_byte)
            report_mismatch("name_byte", 32'(got.name_byte), 32'(want.fields.name_byte));
        if (got.name_valid !== want.fields.name_valid)
            report_mismatch("name_byte_valid", 32'(got.name_valid),
                            32'(want.fields.name_valid));
        if (got.pointer_offset !== want.fields.pointer_offset)
            report_mismatch("pointer_offset", 32'(got.pointer_offset),
                            32'(want.fields.pointer_offset));
        if (got.pointer_seen !== want.fields.pointer_seen)
            report_mismatch("pointer_seen", 32'(got.pointer_seen),
                            32'(want.fields.pointer_seen));
        if (got.parse_error !== want.fields.parse_error)
            report_mismatch("parse_error", 32'(got.parse_error),
                            32'(want.fields.parse_error));
        if (got.pad !== 1'b0) report_mismatch("padding bit", 32'(got.pad), 32'd0);
        if (want.eom) messages_done++;
        if (want.fields.name_valid) name_bytes_seen++;
        if (want.fields.pointer_seen) pointers_seen++;
        if (want.fields.field_done && want.fields.field_id == FID_RDATA) rdata_ends_seen++;
        err_seen[want.fields.parse_error]++;
    endtask

    // Driver: inputs change on the falling edge.
    always @(negedge aclk) begin
        wire_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_fire) begin
                if (send_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    nxt = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Monitor: both channels sampled on the rising edge.
    always @(posedge aclk) begin
        parse_expect_t exp_res;
        if (!aresetn) begin
            s_fire <= 1'b0;
            clear_parser();
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                parse_dns_byte(s_tdata, s_tlast, exp_res);
                pending_results.push_back(exp_res);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("tb_dns_message_parser_core: done, errors");
        $finish;
    end

    initial begin
        load_directed();
        fill_random(PHASE_BYTES, 1'b0);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_for_drain();

        // Second phase: the sender is idle more often than the receiver.
        sender_idle_pct   = 52;
        receiver_idle_pct = 38;
        fill_random(PHASE_BYTES, 1'b1);
        wait_for_drain();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        fill_random(PHASE_BYTES, 1'b0);
        wait_for_drain();
        repeat (8) @(negedge aclk);

        $display("%0d bytes over %0d messages: %0d name bytes, %0d pointers, %0d rdata ends",
                 results_seen, messages_done, name_bytes_seen, pointers_seen, rdata_ends_seen);
        $display("flagged: %0d truncated, %0d reserved label type, %0d long name",
                 err_seen[ERR_TRUNCATED], err_seen[ERR_LABEL_TYPE], err_seen[ERR_NAME_LONG]);
        if (error_count == 0) begin
            $display("tb_dns_message_parser_core: done, clean");
        end else begin
            $display("tb_dns_message_parser_core: done, errors");
        end
        $finish;
    end

endmodule
